/* design/rwsp_pkg.sv */
// Shared types, codes and constant tables for the register write stream player.
// Used by the front end, the job queue, the back end, the top level and the testbench.
package rwsp_pkg;

    // Input item kinds
    typedef enum logic [1:0] {
        KIND_PLAY   = 2'd0,
        KIND_STREAM = 2'd1,
        KIND_STOP   = 2'd2,
        KIND_READ   = 2'd3
    } in_kind_t;

    // Result kinds
    typedef enum logic [2:0] {
        RK_WRITE   = 3'd1,
        RK_FRAME   = 3'd2,
        RK_SEEK    = 3'd3,
        RK_STOPPED = 3'd4,
        RK_ERROR   = 3'd5,
        RK_SHADOW  = 3'd6
    } result_kind_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_LOOP_ENABLE = 2'd0;
    localparam logic [1:0] CFG_WAIT_CODE   = 2'd1;
    localparam logic [1:0] CFG_WRITE_CODE  = 2'd2;
    localparam logic [1:0] CFG_END_CODE    = 2'd3;

    localparam logic [7:0] WAIT_CODE_RESET  = 8'd1;
    localparam logic [7:0] WRITE_CODE_RESET = 8'd2;
    localparam logic [7:0] END_CODE_RESET   = 8'd3;

    // Shadowed address windows
    localparam logic [7:0] REG_LO  = 8'h60;
    localparam logic [7:0] REG_HI  = 8'h88;
    localparam logic [7:0] WAVE_LO = 8'h90;
    localparam logic [7:0] WAVE_HI = 8'h9F;

    localparam int REG_SHADOW_DEPTH = 41;
    localparam int SHADOW_DEPTH     = 57;
    localparam int SHADOW_AW        = 6;

    localparam int SILENCE_LEN = 37;
    localparam int STEP_W      = 6;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        OP_SINGLE,
        OP_SILENCE,
        OP_SILENCE_STOP
    } job_op_t;

    typedef struct packed {
        job_op_t      op;
        result_kind_t rk;
        logic [7:0]   addr;
        logic [7:0]   data;
        logic [7:0]   rdata;
        logic [31:0]  offset;
        logic [31:0]  loops;
    } job_t;

    typedef struct packed {
        result_kind_t rk;
        logic [7:0]   addr;
        logic [7:0]   data;
        logic [7:0]   rdata;
        logic [31:0]  offset;
        logic [31:0]  loops;
        logic         last;
    } beat_t;

    typedef struct packed {
        logic       loop_enable;
        logic [7:0] wait_code;
        logic [7:0] write_code;
        logic [7:0] end_code;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Silencing sequence: {address, data}
    localparam logic [15:0] SILENCE_SEQ [0:SILENCE_LEN-1] = '{
        16'h8480,
        16'h6000, 16'h6200, 16'h6308, 16'h6400, 16'h6580,
        16'h6800, 16'h6908, 16'h6C00, 16'h6D80,
        16'h9080, 16'h9180, 16'h9280, 16'h9380,
        16'h9480, 16'h9580, 16'h9680, 16'h9780,
        16'h9880, 16'h9980, 16'h9A80, 16'h9B80,
        16'h9C80, 16'h9D80, 16'h9E80, 16'h9F80,
        16'h7000, 16'h7200, 16'h7300, 16'h7400, 16'h7500,
        16'h7800, 16'h7908, 16'h7C00, 16'h7D80,
        16'h8077, 16'h81FF
    };

    // Value of a shadow entry that has not been written since play or reset
    function automatic logic [7:0] shadow_init(logic [SHADOW_AW-1:0] idx);
        logic [7:0] v;
        case (idx)
            6'h20:   v = 8'h77;
            6'h21:   v = 8'hFF;
            6'h24:   v = 8'h80;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

/* design/rwsp_if.sv */
// Channel interfaces of the register write stream player: command input,
// result output and configuration write port. Depends on nothing.
interface rwsp_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] stream_byte;
    logic [5:0] shadow_index;

    modport source (output valid, output kind, output stream_byte, output shadow_index,
                    input ready);
    modport sink (input valid, input kind, input stream_byte, input shadow_index,
                  output ready);
endinterface

interface rwsp_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  result_kind;
    logic [7:0]  write_addr;
    logic [7:0]  write_data;
    logic [7:0]  read_data;
    logic [31:0] play_offset;
    logic [31:0] loop_count;
    logic        last;

    modport source (output valid, output result_kind, output write_addr, output write_data,
                    output read_data, output play_offset, output loop_count, output last,
                    input ready);
    modport sink (input valid, input result_kind, input write_addr, input write_data,
                  input read_data, input play_offset, input loop_count, input last,
                  output ready);
endinterface

interface rwsp_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* design/rwsp_front.sv */
// Front end: accepts command items, parses the stream, keeps playback state and
// the shadow store, and hands one job per result group to the queue. Uses rwsp_pkg.
module rwsp_front #(
    parameter int OFFSET_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    rwsp_cmd_if.sink            cmd,
    input  rwsp_pkg::cfg_t      cfg,
    input  rwsp_pkg::q_status_t q_status,
    output logic                q_push,
    output rwsp_pkg::job_t      q_job
);

    typedef enum logic [2:0] {
        PH_CMD,
        PH_ADDR,
        PH_DATA,
        PH_OFS0,
        PH_OFS1,
        PH_OFS2,
        PH_OFS3
    } phase_t;

    localparam int SAW = rwsp_pkg::SHADOW_AW;

    phase_t                   phase_reg, phase_next;
    logic                     playing_reg, playing_next;
    logic [7:0]               held_addr_reg, held_addr_next;
    logic [23:0]              loop_asm_reg, loop_asm_next;
    logic [OFFSET_BITS-1:0]   pos_reg, pos_next;
    logic [31:0]              loops_reg, loops_next;
    logic [rwsp_pkg::SHADOW_DEPTH-1:0] sh_valid_reg, sh_valid_next;
    logic                     s2_valid_reg, s2_valid_next;

    rwsp_pkg::job_t           s2_job_reg, job_next;
    logic                     s2_read_reg;

    logic [7:0]               shadow_mem [0:rwsp_pkg::SHADOW_DEPTH-1];
    logic [7:0]               rd_data_reg;
    logic [7:0]               rd_init_reg;
    logic                     rd_hit_reg;
    logic                     rd_inrange_reg;

    logic                     accept;
    logic                     job_load;
    logic                     is_read;
    logic                     sh_wr;
    logic [SAW-1:0]           sh_waddr;
    logic                     rd_en;
    logic                     rd_inrange;
    logic [SAW-1:0]           rd_addr;
    logic [7:0]               held_sub;
    logic [31:0]              seek_target;
    rwsp_pkg::in_kind_t       kind;

    assign cmd.ready = !s2_valid_reg || !q_status.full;
    assign accept    = cmd.valid && cmd.ready;
    assign q_push    = s2_valid_reg && !q_status.full;
    assign kind      = rwsp_pkg::in_kind_t'(cmd.kind);

    assign rd_inrange  = cmd.shadow_index <= SAW'(rwsp_pkg::SHADOW_DEPTH - 1);
    assign rd_addr     = rd_inrange ? cmd.shadow_index : '0;
    assign held_sub    = held_addr_reg - rwsp_pkg::REG_LO;
    assign seek_target = {cmd.stream_byte, loop_asm_reg};

    always_comb
    begin
        phase_next     = phase_reg;
        playing_next   = playing_reg;
        held_addr_next = held_addr_reg;
        loop_asm_next  = loop_asm_reg;
        pos_next       = pos_reg;
        loops_next     = loops_reg;
        sh_valid_next  = sh_valid_reg;
        job_load       = 1'b0;
        is_read        = 1'b0;
        sh_wr          = 1'b0;
        sh_waddr       = '0;
        rd_en          = 1'b0;
        job_next       = '0;
        job_next.op    = rwsp_pkg::OP_SINGLE;
        job_next.rk    = rwsp_pkg::RK_FRAME;

        if (accept)
        begin
            case (kind)
                rwsp_pkg::KIND_PLAY:
                begin
                    sh_valid_next  = '0;
                    pos_next       = '0;
                    loops_next     = '0;
                    phase_next     = PH_CMD;
                    held_addr_next = '0;
                    loop_asm_next  = '0;
                    playing_next   = 1'b1;
                    job_load       = 1'b1;
                    job_next.op    = rwsp_pkg::OP_SILENCE;
                end
                rwsp_pkg::KIND_STOP:
                begin
                    playing_next = 1'b0;
                    phase_next   = PH_CMD;
                    job_load     = 1'b1;
                    job_next.op  = rwsp_pkg::OP_SILENCE_STOP;
                end
                rwsp_pkg::KIND_READ:
                begin
                    rd_en       = 1'b1;
                    is_read     = 1'b1;
                    job_load    = 1'b1;
                    job_next.rk = rwsp_pkg::RK_SHADOW;
                end
                rwsp_pkg::KIND_STREAM:
                begin
                    if (playing_reg)
                    begin
                        pos_next = pos_reg + OFFSET_BITS'(1);
                        case (phase_reg)
                            PH_CMD:
                            begin
                                if (cmd.stream_byte == cfg.wait_code)
                                begin
                                    job_load    = 1'b1;
                                    job_next.rk = rwsp_pkg::RK_FRAME;
                                end
                                else if (cmd.stream_byte == cfg.write_code)
                                begin
                                    phase_next = PH_ADDR;
                                end
                                else if (cmd.stream_byte == cfg.end_code)
                                begin
                                    if (cfg.loop_enable)
                                    begin
                                        loop_asm_next = '0;
                                        phase_next    = PH_OFS0;
                                    end
                                    else
                                    begin
                                        playing_next = 1'b0;
                                        job_load     = 1'b1;
                                        job_next.op  = rwsp_pkg::OP_SILENCE_STOP;
                                    end
                                end
                                else
                                begin
                                    playing_next = 1'b0;
                                    job_load     = 1'b1;
                                    job_next.rk  = rwsp_pkg::RK_ERROR;
                                end
                            end
                            PH_ADDR:
                            begin
                                held_addr_next = cmd.stream_byte;
                                phase_next     = PH_DATA;
                            end
                            PH_DATA:
                            begin
                                if (held_addr_reg >= rwsp_pkg::REG_LO &&
                                    held_addr_reg <= rwsp_pkg::REG_HI)
                                begin
                                    sh_wr    = 1'b1;
                                    sh_waddr = held_sub[SAW-1:0];
                                end
                                if (held_addr_reg >= rwsp_pkg::WAVE_LO &&
                                    held_addr_reg <= rwsp_pkg::WAVE_HI)
                                begin
                                    sh_wr    = 1'b1;
                                    sh_waddr = SAW'(rwsp_pkg::REG_SHADOW_DEPTH) +
                                               SAW'(held_addr_reg[3:0]);
                                end
                                if (sh_wr)
                                begin
                                    sh_valid_next[sh_waddr] = 1'b1;
                                end
                                phase_next    = PH_CMD;
                                job_load      = 1'b1;
                                job_next.rk   = rwsp_pkg::RK_WRITE;
                                job_next.addr = held_addr_reg;
                                job_next.data = cmd.stream_byte;
                            end
                            PH_OFS0:
                            begin
                                loop_asm_next = {16'h0000, cmd.stream_byte};
                                phase_next    = PH_OFS1;
                            end
                            PH_OFS1:
                            begin
                                loop_asm_next[15:8] = cmd.stream_byte;
                                phase_next          = PH_OFS2;
                            end
                            PH_OFS2:
                            begin
                                loop_asm_next[23:16] = cmd.stream_byte;
                                phase_next           = PH_OFS3;
                            end
                            PH_OFS3:
                            begin
                                pos_next    = seek_target[OFFSET_BITS-1:0];
                                loops_next  = loops_reg + 32'd1;
                                phase_next  = PH_CMD;
                                job_load    = 1'b1;
                                job_next.rk = rwsp_pkg::RK_SEEK;
                            end
                            default:
                            begin
                                phase_next = PH_CMD;
                            end
                        endcase
                    end
                end
                default:
                begin
                    job_load = 1'b0;
                end
            endcase
        end

        // every result carries the position and loop count after the item
        job_next.offset = 32'(pos_next);
        job_next.loops  = loops_next;

        if (accept)
        begin
            s2_valid_next = job_load;
        end
        else if (q_push)
        begin
            s2_valid_next = 1'b0;
        end
        else
        begin
            s2_valid_next = s2_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_CMD;
            playing_reg   <= 1'b0;
            held_addr_reg <= '0;
            loop_asm_reg  <= '0;
            pos_reg       <= '0;
            loops_reg     <= '0;
            sh_valid_reg  <= '0;
            s2_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            playing_reg   <= playing_next;
            held_addr_reg <= held_addr_next;
            loop_asm_reg  <= loop_asm_next;
            pos_reg       <= pos_next;
            loops_reg     <= loops_next;
            sh_valid_reg  <= sh_valid_next;
            s2_valid_reg  <= s2_valid_next;
        end
    end

    // hold the job while the queue is full
    always_ff @(posedge clk)
    begin
        if (accept && job_load)
        begin
            s2_job_reg  <= job_next;
            s2_read_reg <= is_read;
        end
    end

    // shadow store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (sh_wr)
        begin
            shadow_mem[sh_waddr] <= cmd.stream_byte;
        end
        if (rd_en)
        begin
            rd_data_reg    <= shadow_mem[rd_addr];
            rd_hit_reg     <= sh_valid_reg[rd_addr];
            rd_init_reg    <= rwsp_pkg::shadow_init(rd_addr);
            rd_inrange_reg <= rd_inrange;
        end
    end

    always_comb
    begin
        q_job = s2_job_reg;
        if (s2_read_reg)
        begin
            if (!rd_inrange_reg)
            begin
                q_job.rdata = 8'h00;
            end
            else if (rd_hit_reg)
            begin
                q_job.rdata = rd_data_reg;
            end
            else
            begin
                q_job.rdata = rd_init_reg;
            end
        end
    end

endmodule

/* design/rwsp_fifo.sv */
// Short job queue between the front end and the back end.
// Uses rwsp_pkg for the job type and the depth.
module rwsp_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rwsp_pkg::job_t      push_job,
    input  logic                pop,
    output rwsp_pkg::job_t      head,
    output rwsp_pkg::q_status_t status
);

    localparam int PW = rwsp_pkg::QUEUE_PW;

    rwsp_pkg::job_t   slots [0:rwsp_pkg::QUEUE_DEPTH-1];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW:0]      count_reg;

    assign head         = slots[rd_ptr_reg];
    assign status.full  = count_reg == (PW + 1)'(rwsp_pkg::QUEUE_DEPTH);
    assign status.empty = count_reg == '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (PW + 1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (PW + 1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* design/rwsp_back.sv */
// Back end: expands the job at the queue head into result beats, walking the
// silencing sequence for play and stop, into a registered output. Uses rwsp_pkg.
module rwsp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  rwsp_pkg::q_status_t q_status,
    input  rwsp_pkg::job_t      q_job,
    output logic                q_pop,
    rwsp_result_if.source       result
);

    localparam int SW = rwsp_pkg::STEP_W;

    logic [SW-1:0]   step_reg;
    logic            out_valid_reg;
    rwsp_pkg::beat_t beat_reg;
    rwsp_pkg::beat_t beat;
    logic [SW-1:0]   last_step;
    logic [SW-1:0]   seq_idx;
    logic [15:0]     seq_entry;
    logic            adv;

    assign adv       = !out_valid_reg || result.ready;
    assign seq_idx   = (step_reg < SW'(rwsp_pkg::SILENCE_LEN)) ? step_reg : '0;
    assign seq_entry = rwsp_pkg::SILENCE_SEQ[seq_idx];

    always_comb
    begin
        case (q_job.op)
            rwsp_pkg::OP_SINGLE:       last_step = '0;
            rwsp_pkg::OP_SILENCE:      last_step = SW'(rwsp_pkg::SILENCE_LEN - 1);
            rwsp_pkg::OP_SILENCE_STOP: last_step = SW'(rwsp_pkg::SILENCE_LEN);
            default:                   last_step = '0;
        endcase

        beat        = '0;
        beat.offset = q_job.offset;
        beat.loops  = q_job.loops;
        beat.last   = step_reg == last_step;
        if (q_job.op == rwsp_pkg::OP_SINGLE)
        begin
            beat.rk    = q_job.rk;
            beat.addr  = q_job.addr;
            beat.data  = q_job.data;
            beat.rdata = q_job.rdata;
        end
        else if (step_reg < SW'(rwsp_pkg::SILENCE_LEN))
        begin
            beat.rk   = rwsp_pkg::RK_WRITE;
            beat.addr = seq_entry[15:8];
            beat.data = seq_entry[7:0];
        end
        else
        begin
            beat.rk = rwsp_pkg::RK_STOPPED;
        end
    end

    // drop the job once its final beat is registered
    assign q_pop = adv && !q_status.empty && beat.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= !q_status.empty;
            if (!q_status.empty)
            begin
                step_reg <= beat.last ? '0 : step_reg + SW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && !q_status.empty)
        begin
            beat_reg <= beat;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.result_kind = beat_reg.rk;
    assign result.write_addr  = beat_reg.addr;
    assign result.write_data  = beat_reg.data;
    assign result.read_data   = beat_reg.rdata;
    assign result.play_offset = beat_reg.offset;
    assign result.loop_count  = beat_reg.loops;
    assign result.last        = beat_reg.last;

endmodule

/* design/register_write_stream_player.sv */
// Register write stream player: takes one command item per cycle (play, stream
// byte, stop, shadow read) while no job waits on a full queue, and turns the
// sound-register command stream into result beats. A byte that completes a
// command yields one beat, play yields the 37-write silencing sequence and stop
// (or an end command without loop) yields 38 beats, all drained by the output
// stage at one beat per cycle while the result sink is ready, so play and stop
// set the sustained rate while they run. A four-job queue sits between the
// parser and the beat generator; a result passes the parser stage register,
// the queue slot and the output register after its item is accepted. Shadow
// reads go through a registered memory port; entries not written since play or
// reset read their reset value through per-entry valid bits, so no clearing
// pass is needed. Configuration writes are always ready.
module register_write_stream_player #(
    parameter int OFFSET_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    rwsp_cmd_if.sink      cmd,
    rwsp_cfg_if.sink      cfg,
    rwsp_result_if.source result
);

    rwsp_pkg::cfg_t      cfg_reg;
    rwsp_pkg::q_status_t q_st;
    rwsp_pkg::job_t      push_job;
    rwsp_pkg::job_t      head_job;
    logic                q_push;
    logic                q_pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.loop_enable <= 1'b0;
            cfg_reg.wait_code   <= rwsp_pkg::WAIT_CODE_RESET;
            cfg_reg.write_code  <= rwsp_pkg::WRITE_CODE_RESET;
            cfg_reg.end_code    <= rwsp_pkg::END_CODE_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                rwsp_pkg::CFG_LOOP_ENABLE: cfg_reg.loop_enable <= cfg.data[0];
                rwsp_pkg::CFG_WAIT_CODE:   cfg_reg.wait_code   <= cfg.data;
                rwsp_pkg::CFG_WRITE_CODE:  cfg_reg.write_code  <= cfg.data;
                rwsp_pkg::CFG_END_CODE:    cfg_reg.end_code    <= cfg.data;
                default:                   cfg_reg.loop_enable <= cfg_reg.loop_enable;
            endcase
        end
    end

    rwsp_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg_reg),
        .q_status (q_st),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    rwsp_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head     (head_job),
        .status   (q_st)
    );

    rwsp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_st),
        .q_job    (head_job),
        .q_pop    (q_pop),
        .result   (result)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_st.full)
        else $error("job pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_st.empty)
        else $error("job popped from an empty queue");

    a_single_beats_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.result_kind != rwsp_pkg::RK_WRITE) |-> result.last)
        else $error("non-write result not marked last");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid |-> cfg.ready)
        else $error("configuration write not accepted");

endmodule

/* verif/tb_register_write_stream_player.sv */
// Self-checking testbench for register_write_stream_player: drives command beats,
// predicts every result beat in-line and compares each beat as it leaves the block.
// Depends on design/rwsp_pkg.sv, design/rwsp_if.sv and the block itself.
module tb_register_write_stream_player;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT   = 40000;

    // Parse phases of the command stream
    typedef enum int {
        PH_CMD,
        PH_ADDR,
        PH_DATA,
        PH_OFS0,
        PH_OFS1,
        PH_OFS2,
        PH_OFS3
    } parse_phase_t;

    logic clk = 1'b0;
    logic rst_n;

    rwsp_cmd_if    cmd_bus();
    rwsp_cfg_if    cfg_bus();
    rwsp_result_if res_bus();

    register_write_stream_player dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_bus),
        .cfg    (cfg_bus),
        .result (res_bus)
    );

    always #10 clk = ~clk;

    // Player copy: settings and state
    logic         loop_on;
    logic [7:0]   wait_cmd;
    logic [7:0]   write_cmd;
    logic [7:0]   end_cmd;
    logic         now_playing;
    parse_phase_t phase;
    logic [7:0]   held_addr;
    logic [23:0]  offset_bytes;
    logic [31:0]  byte_pos;
    logic [31:0]  loops_taken;
    logic [7:0]   reg_copy [0:40];
    logic [7:0]   wave_copy [0:15];

    rwsp_pkg::beat_t expected_beats[$];

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int errors = 0;
    int items_accepted = 0;
    int beats_checked = 0;
    int kind_seen [0:7];

    function automatic void restore_shadows();
        for (int i = 0; i <= 40; i++)
            reg_copy[i] = 8'h00;
        for (int i = 0; i < 16; i++)
            wave_copy[i] = 8'h00;
        reg_copy[32] = 8'h77;
        reg_copy[33] = 8'hFF;
        reg_copy[36] = 8'h80;
    endfunction

    function automatic void push_beat(rwsp_pkg::result_kind_t rk, logic [7:0] addr,
                                      logic [7:0] data, logic [7:0] rdata);
        rwsp_pkg::beat_t b;
        b.rk     = rk;
        b.addr   = addr;
        b.data   = data;
        b.rdata  = rdata;
        b.offset = byte_pos;
        b.loops  = loops_taken;
        b.last   = 1'b0;
        expected_beats.push_back(b);
    endfunction

    function automatic void push_silence();
        for (int i = 0; i < rwsp_pkg::SILENCE_LEN; i++)
            push_beat(rwsp_pkg::RK_WRITE, rwsp_pkg::SILENCE_SEQ[i][15:8],
                      rwsp_pkg::SILENCE_SEQ[i][7:0], 8'h00);
    endfunction

    function automatic void halt_playback();
        push_silence();
        now_playing = 1'b0;
        phase = PH_CMD;
        push_beat(rwsp_pkg::RK_STOPPED, 8'h00, 8'h00, 8'h00);
    endfunction

    // Advance the player copy by one accepted command and queue the beats it causes
    function automatic void predict_beats(rwsp_pkg::in_kind_t k, logic [7:0] b,
                                          logic [5:0] idx);
        int before_n;
        logic [7:0] v;
        before_n = expected_beats.size();
        case (k)
            rwsp_pkg::KIND_PLAY: begin
                restore_shadows();
                byte_pos = '0;
                loops_taken = '0;
                phase = PH_CMD;
                held_addr = '0;
                offset_bytes = '0;
                push_silence();
                now_playing = 1'b1;
            end
            rwsp_pkg::KIND_STOP: halt_playback();
            rwsp_pkg::KIND_READ: begin
                if (idx <= 40)
                    v = reg_copy[idx];
                else if (idx <= 56)
                    v = wave_copy[idx - 41];
                else
                    v = 8'h00;
                push_beat(rwsp_pkg::RK_SHADOW, 8'h00, 8'h00, v);
            end
            default: begin
                if (now_playing) begin
                    byte_pos = byte_pos + 1;
                    case (phase)
                        PH_CMD: begin
                            if (b == wait_cmd)
                                push_beat(rwsp_pkg::RK_FRAME, 8'h00, 8'h00, 8'h00);
                            else if (b == write_cmd)
                                phase = PH_ADDR;
                            else if (b == end_cmd) begin
                                if (loop_on) begin
                                    offset_bytes = '0;
                                    phase = PH_OFS0;
                                end
                                else
                                    halt_playback();
                            end
                            else begin
                                now_playing = 1'b0;
                                phase = PH_CMD;
                                push_beat(rwsp_pkg::RK_ERROR, 8'h00, 8'h00, 8'h00);
                            end
                        end
                        PH_ADDR: begin
                            held_addr = b;
                            phase = PH_DATA;
                        end
                        PH_DATA: begin
                            if (held_addr >= rwsp_pkg::REG_LO && held_addr <= rwsp_pkg::REG_HI)
                                reg_copy[held_addr - rwsp_pkg::REG_LO] = b;
                            if (held_addr >= rwsp_pkg::WAVE_LO &&
                                held_addr <= rwsp_pkg::WAVE_HI)
                                wave_copy[held_addr - rwsp_pkg::WAVE_LO] = b;
                            phase = PH_CMD;
                            push_beat(rwsp_pkg::RK_WRITE, held_addr, b, 8'h00);
                        end
                        PH_OFS0: begin
                            offset_bytes = {16'h0000, b};
                            phase = PH_OFS1;
                        end
                        PH_OFS1: begin
                            offset_bytes[15:8] = b;
                            phase = PH_OFS2;
                        end
                        PH_OFS2: begin
                            offset_bytes[23:16] = b;
                            phase = PH_OFS3;
                        end
                        default: begin
                            byte_pos = {b, offset_bytes};
                            loops_taken = loops_taken + 1;
                            phase = PH_CMD;
                            push_beat(rwsp_pkg::RK_SEEK, 8'h00, 8'h00, 8'h00);
                        end
                    endcase
                end
            end
        endcase
        if (expected_beats.size() > before_n)
            expected_beats[expected_beats.size() - 1].last = 1'b1;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v) begin
            errors++;
            $display("%0t: beat %0d %s mismatch: expected %h, actual %h",
                     $time, beats_checked, name, want_v, got_v);
        end
    endfunction

    // Result side: check each accepted beat, then pick the next ready value
    always @(posedge clk) begin
        rwsp_pkg::beat_t want;
        if (rst_n && res_bus.valid && res_bus.ready) begin
            if (expected_beats.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, expected none, actual kind %0d addr %h data %h",
                         $time, res_bus.result_kind, res_bus.write_addr, res_bus.write_data);
            end
            else begin
                want = expected_beats.pop_front();
                compare_field("result_kind", want.rk, res_bus.result_kind);
                compare_field("write_addr", want.addr, res_bus.write_addr);
                compare_field("write_data", want.data, res_bus.write_data);
                compare_field("read_data", want.rdata, res_bus.read_data);
                compare_field("play_offset", want.offset, res_bus.play_offset);
                compare_field("loop_count", want.loops, res_bus.loop_count);
                compare_field("last", want.last, res_bus.last);
                kind_seen[want.rk]++;
                beats_checked++;
            end
        end
        res_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic send_cmd(rwsp_pkg::in_kind_t k, logic [7:0] b = 8'h00,
                            logic [5:0] idx = 6'h00);
        if (k != rwsp_pkg::KIND_STREAM)
            b = 8'($urandom_range(255));
        if (k != rwsp_pkg::KIND_READ)
            idx = 6'($urandom_range(63));
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_bus.valid        <= 1'b1;
        cmd_bus.kind         <= k;
        cmd_bus.stream_byte  <= b;
        cmd_bus.shadow_index <= idx;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        // stray stream bytes while stopped do not count as traffic
        if (k != rwsp_pkg::KIND_STREAM || now_playing)
            items_accepted++;
        predict_beats(k, b, idx);
    endtask

    task automatic put_write(logic [7:0] addr, logic [7:0] data);
        send_cmd(rwsp_pkg::KIND_STREAM, write_cmd);
        send_cmd(rwsp_pkg::KIND_STREAM, addr);
        send_cmd(rwsp_pkg::KIND_STREAM, data);
    endtask

    task automatic put_seek(logic [31:0] target);
        send_cmd(rwsp_pkg::KIND_STREAM, end_cmd);
        for (int i = 0; i < 4; i++)
            send_cmd(rwsp_pkg::KIND_STREAM, target[8*i +: 8]);
    endtask

    // Hold the command side idle until every expected beat is back, then settle
    task automatic drain_results();
        int waited;
        waited = 0;
        cmd_bus.valid <= 1'b0;
        while (expected_beats.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        if (expected_beats.size() != 0) begin
            errors++;
            $display("%0t: %0d expected beats never arrived, first expected kind %0d",
                     $time, expected_beats.size(), expected_beats[0].rk);
            expected_beats.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(logic [1:0] index, logic [7:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= index;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        cfg_bus.valid <= 1'b0;
        case (index)
            rwsp_pkg::CFG_LOOP_ENABLE: loop_on = value[0];
            rwsp_pkg::CFG_WAIT_CODE:   wait_cmd = value;
            rwsp_pkg::CFG_WRITE_CODE:  write_cmd = value;
            default:                   end_cmd = value;
        endcase
        @(posedge clk);
    endtask

    function automatic logic [7:0] pick_addr();
        if ($urandom_range(99) < 70)
            return 8'($urandom_range(8'hA1, 8'h5E));
        return 8'($urandom_range(255));
    endfunction

    task automatic test_after_reset();
        send_cmd(rwsp_pkg::KIND_READ, 8'h00, 6'd32);
        send_cmd(rwsp_pkg::KIND_READ, 8'h00, 6'd63);
        send_cmd(rwsp_pkg::KIND_STREAM, 8'hFF);
        send_cmd(rwsp_pkg::KIND_STOP);
        drain_results();
    endtask

    task automatic test_shadow_windows();
        send_cmd(rwsp_pkg::KIND_PLAY);
        put_write(rwsp_pkg::REG_LO, 8'hFF);
        put_write(rwsp_pkg::REG_HI, 8'h01);
        put_write(rwsp_pkg::WAVE_HI, 8'h80);
        put_write(8'h8F, 8'h7E);
        send_cmd(rwsp_pkg::KIND_STREAM, wait_cmd);
        send_cmd(rwsp_pkg::KIND_READ, 8'h00, 6'd0);
        send_cmd(rwsp_pkg::KIND_READ, 8'h00, 6'd40);
        send_cmd(rwsp_pkg::KIND_READ, 8'h00, 6'd56);
        // end without looping stops playback
        send_cmd(rwsp_pkg::KIND_STREAM, end_cmd);
        drain_results();
    endtask

    task automatic test_loop_wrap();
        cfg_write(rwsp_pkg::CFG_LOOP_ENABLE, 8'h01);
        cfg_write(rwsp_pkg::CFG_WAIT_CODE, 8'h00);
        cfg_write(rwsp_pkg::CFG_WRITE_CODE, 8'hFF);
        cfg_write(rwsp_pkg::CFG_END_CODE, 8'h80);
        send_cmd(rwsp_pkg::KIND_PLAY);
        put_seek(32'hFFFF_FFFF);
        // next byte wraps the position to zero
        send_cmd(rwsp_pkg::KIND_STREAM, 8'h00);
        put_write(8'h00, 8'hFF);
        send_cmd(rwsp_pkg::KIND_STREAM, 8'h7F);
        drain_results();
    endtask

    task automatic test_random_traffic(int src_pct, int snk_pct, int n_items, logic loop_mode,
                                       logic allow_clash);
        int goal;
        int r;
        logic [31:0] target;
        logic [7:0] codes [0:2];
        for (int i = 0; i < 3; i++) begin
            if (allow_clash)
                codes[i] = 8'($urandom_range(3));
            else begin
                do
                    codes[i] = 8'($urandom_range(255));
                while ((i > 0 && codes[i] == codes[0]) || (i > 1 && codes[i] == codes[1]));
            end
        end
        cfg_write(rwsp_pkg::CFG_LOOP_ENABLE, {7'd0, loop_mode});
        cfg_write(rwsp_pkg::CFG_WAIT_CODE, codes[0]);
        cfg_write(rwsp_pkg::CFG_WRITE_CODE, codes[1]);
        cfg_write(rwsp_pkg::CFG_END_CODE, codes[2]);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        goal = items_accepted + n_items;
        send_cmd(rwsp_pkg::KIND_PLAY);
        while (items_accepted < goal) begin
            r = $urandom_range(99);
            if (!now_playing && r < 80)
                send_cmd(rwsp_pkg::KIND_PLAY);
            else if (r < 40)
                put_write(pick_addr(), 8'($urandom_range(255)));
            else if (r < 52)
                send_cmd(rwsp_pkg::KIND_STREAM, wait_cmd);
            else if (r < 60) begin
                case ($urandom_range(2))
                    0:       target = $urandom;
                    1:       target = $urandom_range(255);
                    default: target = 32'hFFFF_FFFF;
                endcase
                if (loop_on)
                    put_seek(target);
                else
                    send_cmd(rwsp_pkg::KIND_STREAM, end_cmd);
            end
            else if (r < 70)
                send_cmd(rwsp_pkg::KIND_READ, 8'h00, 6'($urandom_range(63)));
            else if (r < 86) begin
                // broken sequences: interrupt a command half way, or send a stray byte
                case ($urandom_range(3))
                    0: begin
                        send_cmd(rwsp_pkg::KIND_STREAM, write_cmd);
                        send_cmd(rwsp_pkg::KIND_STREAM, pick_addr());
                        send_cmd(rwsp_pkg::KIND_READ, 8'h00, 6'($urandom_range(63)));
                        send_cmd(rwsp_pkg::KIND_STREAM, 8'($urandom_range(255)));
                    end
                    1: begin
                        send_cmd(rwsp_pkg::KIND_STREAM, write_cmd);
                        send_cmd($urandom_range(1) ? rwsp_pkg::KIND_STOP : rwsp_pkg::KIND_PLAY);
                    end
                    2: begin
                        send_cmd(rwsp_pkg::KIND_STREAM, end_cmd);
                        repeat ($urandom_range(3, 1))
                            send_cmd(rwsp_pkg::KIND_STREAM, 8'($urandom_range(255)));
                        send_cmd($urandom_range(1) ? rwsp_pkg::KIND_STOP : rwsp_pkg::KIND_PLAY);
                    end
                    default: send_cmd(rwsp_pkg::KIND_STREAM, 8'($urandom_range(255)));
                endcase
            end
            else if (r < 92)
                send_cmd(rwsp_pkg::KIND_STOP);
            else if (r < 95)
                send_cmd(rwsp_pkg::KIND_PLAY);
            else
                send_cmd(rwsp_pkg::KIND_STREAM, 8'($urandom_range(255)));
        end
        drain_results();
    endtask

    initial begin
        for (int i = 0; i < 8; i++)
            kind_seen[i] = 0;
        loop_on      = 1'b0;
        wait_cmd     = rwsp_pkg::WAIT_CODE_RESET;
        write_cmd    = rwsp_pkg::WRITE_CODE_RESET;
        end_cmd      = rwsp_pkg::END_CODE_RESET;
        now_playing  = 1'b0;
        phase        = PH_CMD;
        held_addr    = '0;
        offset_bytes = '0;
        byte_pos     = '0;
        loops_taken  = '0;
        restore_shadows();

        rst_n                <= 1'b0;
        cmd_bus.valid        <= 1'b0;
        cmd_bus.kind         <= rwsp_pkg::KIND_PLAY;
        cmd_bus.stream_byte  <= 8'h00;
        cmd_bus.shadow_index <= 6'h00;
        cfg_bus.valid        <= 1'b0;
        cfg_bus.index        <= rwsp_pkg::CFG_LOOP_ENABLE;
        cfg_bus.data         <= 8'h00;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_shadow_windows();
        test_loop_wrap();
        test_random_traffic(18, 85, 72, 1'b1, 1'b0);
        test_random_traffic(85, 18, 72, 1'b0, 1'b0);
        test_random_traffic(0, 0, 72, 1'($urandom_range(1)), 1'b1);

        $display("Ran %0d commands through directed and three randomized idle patterns.",
                 items_accepted);
        $display("Beats checked %0d: writes %0d, frames %0d, seeks %0d,",
                 beats_checked, kind_seen[rwsp_pkg::RK_WRITE], kind_seen[rwsp_pkg::RK_FRAME],
                 kind_seen[rwsp_pkg::RK_SEEK]);
        $display("  stops %0d, errors %0d, reads %0d",
                 kind_seen[rwsp_pkg::RK_STOPPED], kind_seen[rwsp_pkg::RK_ERROR],
                 kind_seen[rwsp_pkg::RK_SHADOW]);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timed out with %0d beats outstanding", expected_beats.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
